// ===== src/nal_start_code_splitter_assert.svh =====
// assertion macros for the nal start code splitter
`ifndef NAL_START_CODE_SPLITTER_ASSERT_SVH
`define NAL_START_CODE_SPLITTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define NSC_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nsc check failed");

// next-cycle implication, checked outside reset
`define NSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nsc check failed");

`endif

// ===== src/nsc_pkg.sv =====
// shared types and constants of the nal start code splitter
package nsc_pkg;

    localparam int MAX_ZEROS  = 3;
    localparam int PREFIX_LEN = 4;
    localparam int PREFIX_AW  = $clog2(PREFIX_LEN);
    localparam int CMD_DEPTH  = 4;
    localparam int CMD_AW     = $clog2(CMD_DEPTH);
    localparam int STEP_W     = 3;

    localparam logic [7:0] PREFIX_BYTES [PREFIX_LEN] = '{8'h00, 8'h00, 8'h00, 8'h01};

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;

    typedef enum logic [2:0] {
        PH_SEARCH0 = 3'd0,
        PH_SEARCH1 = 3'd1,
        PH_SEARCH2 = 3'd2,
        PH_FRESH   = 3'd3,
        PH_BODY    = 3'd4
    } t_phase;

    // work for the back end: held byte, then zeros, then prefix
    typedef struct packed {
        logic       has_held;
        logic [7:0] held_byte;
        logic       held_last;
        logic       fresh;
        logic [1:0] n_zero;
        logic       has_prefix;
    } t_cmd;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       unit_first;
        logic       unit_last;
        logic       run_last;
    } t_beat;

endpackage

// ===== src/nal_start_code_splitter.sv =====
// nal start code splitter top level
//
// input queue side: drive i_data_byte with push; a beat is taken when push is high and
// full is low. one byte per cycle is accepted while the command queue has room.
// result queue side: while empty is low the oldest result beat sits on o_out_byte,
// o_unit_first, o_unit_last and o_run_last; pop takes it. each input byte makes zero
// to five beats; o_run_last marks the last beat made by one input byte.
// path: an accepted byte's command is written into the command queue, and the back end
// then registers each of its beats into the output register.
// throughput: one byte per cycle in while the command queue has room, one beat per
// cycle out while the receiver pops; bytes that make several beats drain one at a time.
// a four-entry command queue separates scanner and beat generator; when the receiver
// stalls the output beat holds and the queue fills, then full rises.
// config: i_cfg_valid with i_cfg_data sets emit_prefix; o_cfg_ready is always high.
// emit_prefix is sampled when a unit begins.
// reset (synchronous, active low) empties the queue and the output, returns the
// scanner to searching for the first start code and sets emit_prefix to 1.
module nal_start_code_splitter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_unit_first,
    output logic       o_unit_last,
    output logic       o_run_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data
);
    import nsc_pkg::*;

    `include "nal_start_code_splitter_assert.svh"

    logic  in_accept;
    logic  cmd_valid;
    t_cmd  cmd;
    logic  cmd_full;
    logic  cmd_empty;
    logic  cmd_pop;
    t_cmd  cmd_head;
    t_beat beat;

    assign o_cfg_ready = 1'b1;
    assign full        = cmd_full;
    assign in_accept   = push && !cmd_full;

    nsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    nsc_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept && cmd_valid),
        .i_cmd   (cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_head  (cmd_head),
        .o_empty (cmd_empty)
    );

    nsc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (cmd_head),
        .i_head_empty (cmd_empty),
        .o_head_pop   (cmd_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_beat       (beat)
    );

    assign o_out_byte   = beat.out_byte;
    assign o_unit_first = beat.unit_first;
    assign o_unit_last  = beat.unit_last;
    assign o_run_last   = beat.run_last;

    // a command leaves the queue only with its final beat, which then shows next cycle
    `NSC_ASSERT_NEXT(cmd_pop_shows_run_last, cmd_pop, !empty && o_run_last)
    `NSC_ASSERT_IMPLIES(no_pop_from_empty_queue, cmd_pop, !cmd_empty)
    `NSC_ASSERT_IMPLIES(no_push_into_full_queue, in_accept && cmd_valid, !cmd_full)

endmodule

// ===== src/nsc_front.sv =====
// front end: start code scanner that turns each accepted byte into at most one command
module nsc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_data_byte,
    input  logic          i_cfg_we,
    input  logic          i_cfg_data,
    output logic          o_cmd_valid,
    output nsc_pkg::t_cmd o_cmd
);
    import nsc_pkg::*;

    t_phase     r_phase,     n_phase;
    logic [1:0] r_zero_run,  n_zero_run;
    logic [7:0] r_held_byte, n_held_byte;
    logic       r_held_valid, n_held_valid;
    logic       r_emit_prefix;

    logic is_zero;
    logic is_one;
    logic in_unit;

    assign is_zero = (i_data_byte == BYTE_ZERO);
    assign is_one  = (i_data_byte == BYTE_ONE);
    assign in_unit = (r_phase == PH_FRESH) || (r_phase == PH_BODY);

    always_comb begin
        n_phase      = r_phase;
        n_zero_run   = r_zero_run;
        n_held_byte  = r_held_byte;
        n_held_valid = r_held_valid;
        o_cmd_valid  = 1'b0;
        o_cmd        = '0;
        o_cmd.fresh  = (r_phase == PH_FRESH);
        if (in_unit) begin
            if (is_zero) begin
                if (r_zero_run < 2'(MAX_ZEROS)) begin
                    n_zero_run = r_zero_run + 2'd1;
                end else begin
                    // held byte becomes payload; the oldest zero of the run is held in its place
                    o_cmd.has_held  = r_held_valid;
                    o_cmd.held_byte = r_held_byte;
                    o_cmd_valid     = r_held_valid;
                    if (r_held_valid) begin
                        n_phase = PH_BODY;
                    end
                    n_held_byte  = BYTE_ZERO;
                    n_held_valid = 1'b1;
                end
            end else if (is_one && r_zero_run >= 2'd2) begin
                o_cmd.has_held   = r_held_valid;
                o_cmd.held_byte  = r_held_byte;
                o_cmd.held_last  = 1'b1;
                o_cmd.has_prefix = r_emit_prefix;
                o_cmd_valid      = r_held_valid || r_emit_prefix;
                n_phase          = r_emit_prefix ? PH_BODY : PH_FRESH;
                n_zero_run       = 2'd0;
                n_held_byte      = BYTE_ZERO;
                n_held_valid     = 1'b0;
            end else begin
                o_cmd.has_held  = r_held_valid;
                o_cmd.held_byte = r_held_byte;
                o_cmd.n_zero    = r_zero_run;
                o_cmd_valid     = r_held_valid || (r_zero_run != 2'd0);
                if (o_cmd_valid) begin
                    n_phase = PH_BODY;
                end
                n_zero_run   = 2'd0;
                n_held_byte  = i_data_byte;
                n_held_valid = 1'b1;
            end
        end else begin
            unique case (r_phase)
                PH_SEARCH1: begin
                    n_phase = is_zero ? PH_SEARCH2 : PH_SEARCH0;
                end
                PH_SEARCH2: begin
                    if (is_one) begin
                        o_cmd.has_prefix = r_emit_prefix;
                        o_cmd_valid      = r_emit_prefix;
                        n_phase          = r_emit_prefix ? PH_BODY : PH_FRESH;
                        n_zero_run       = 2'd0;
                        n_held_byte      = BYTE_ZERO;
                        n_held_valid     = 1'b0;
                    end else if (!is_zero) begin
                        n_phase = PH_SEARCH0;
                    end
                end
                default: begin
                    n_phase = is_zero ? PH_SEARCH1 : PH_SEARCH0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SEARCH0;
            r_zero_run    <= 2'd0;
            r_held_byte   <= BYTE_ZERO;
            r_held_valid  <= 1'b0;
            r_emit_prefix <= 1'b1;
        end else begin
            if (i_accept) begin
                r_phase      <= n_phase;
                r_zero_run   <= n_zero_run;
                r_held_byte  <= n_held_byte;
                r_held_valid <= n_held_valid;
            end
            if (i_cfg_we) begin
                r_emit_prefix <= i_cfg_data;
            end
        end
    end

endmodule

// ===== src/nsc_cmd_fifo.sv =====
// short command queue between front and back end
module nsc_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  nsc_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output nsc_pkg::t_cmd o_head,
    output logic          o_empty
);
    import nsc_pkg::*;

    t_cmd              r_mem [CMD_DEPTH];
    logic [CMD_AW-1:0] r_wr_ptr;
    logic [CMD_AW-1:0] r_rd_ptr;
    logic [CMD_AW:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == (CMD_AW+1)'(CMD_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/nsc_back.sv =====
// back end: expands each command into output beats, one per cycle while the receiver pops
module nsc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  nsc_pkg::t_cmd i_head,
    input  logic          i_head_empty,
    output logic          o_head_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output nsc_pkg::t_beat o_beat
);
    import nsc_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    t_beat             r_beat;

    logic [STEP_W-1:0] n_beats;
    logic [STEP_W-1:0] j;
    logic [STEP_W-1:0] p;
    t_beat             beat;
    logic              load;

    always_comb begin
        n_beats = STEP_W'(i_head.has_held) + STEP_W'(i_head.n_zero)
                + (i_head.has_prefix ? STEP_W'(PREFIX_LEN) : '0);
        j = r_step - STEP_W'(i_head.has_held);
        p = j - STEP_W'(i_head.n_zero);
        beat = '0;
        if (i_head.has_held && r_step == '0) begin
            beat.out_byte   = i_head.held_byte;
            beat.unit_first = i_head.fresh;
            beat.unit_last  = i_head.held_last;
        end else if (j < STEP_W'(i_head.n_zero)) begin
            beat.out_byte   = BYTE_ZERO;
            beat.unit_first = i_head.fresh && !i_head.has_held && (j == '0);
        end else begin
            // prefix of the next unit
            beat.out_byte   = PREFIX_BYTES[p[PREFIX_AW-1:0]];
            beat.unit_first = (p == '0);
        end
        beat.run_last = (r_step == n_beats - 1'b1);
    end

    assign load       = !i_head_empty && (!r_out_valid || i_pop);
    assign o_head_pop = load && beat.run_last;
    assign o_empty    = !r_out_valid;
    assign o_beat     = r_beat;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_beat <= beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_step      <= beat.run_last ? '0 : r_step + 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
